>>> src/pctra_pkg.sv
// Package for the pixel-to-camera ray block: widths, latencies, register codes,
// the arctangent table and the structs shared by the modules.
// Depends on nothing; cfg, div, cordic, lane, top and bench files use it by scoped names.
`timescale 1ns / 1ps

package pctra_pkg;

	// Number of vectoring iterations, capped at the table length.
	localparam int CORDIC_STEPS = 16;
	localparam int MAX_STEPS    = 24;
	localparam int STEPS        = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

	// Quotient bits of the restoring divider: a 32-bit product shifted by 4.
	localparam int DIV_BITS = 36;
	// Delay that lines the angle up with the quotient.
	localparam int ANG_DLY  = DIV_BITS - STEPS;
	// Input register, product register, divider stages, output register.
	localparam int LATENCY  = DIV_BITS + 3;

	localparam logic [19:0] FOCAL_MIN   = 20'd16;
	localparam logic signed [16:0] ANGLE_HI = 17'sd25736;
	localparam logic signed [16:0] ANGLE_LO = -17'sd25736;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_PRINCIPAL_X = 2'd0;
	localparam logic [1:0] REG_PRINCIPAL_Y = 2'd1;
	localparam logic [1:0] REG_FOCAL_X     = 2'd2;
	localparam logic [1:0] REG_FOCAL_Y     = 2'd3;

	localparam logic [15:0] RST_PRINCIPAL_X = 16'd5120;
	localparam logic [15:0] RST_PRINCIPAL_Y = 16'd3840;
	localparam logic [19:0] RST_FOCAL       = 20'd16384;

	typedef struct packed {
		logic [15:0] principal_x;
		logic [15:0] principal_y;
		logic [19:0] focal_x;
		logic [19:0] focal_y;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] coord;
		logic               sat;
		logic signed [15:0] angle;
	} lane_res_t;

	// atan(2^-i) in Q2.30.
	function automatic logic signed [31:0] atan_q30(input int idx);
		logic signed [31:0] r;
		case (idx)
			0:  r = 32'sd843314857;
			1:  r = 32'sd497837830;
			2:  r = 32'sd263043837;
			3:  r = 32'sd133525159;
			4:  r = 32'sd67021687;
			5:  r = 32'sd33543516;
			6:  r = 32'sd16775852;
			7:  r = 32'sd8388438;
			8:  r = 32'sd4194283;
			9:  r = 32'sd2097149;
			10: r = 32'sd1048576;
			11: r = 32'sd524288;
			12: r = 32'sd262144;
			13: r = 32'sd131072;
			14: r = 32'sd65536;
			15: r = 32'sd32768;
			16: r = 32'sd16384;
			17: r = 32'sd8192;
			18: r = 32'sd4096;
			19: r = 32'sd2048;
			20: r = 32'sd1024;
			21: r = 32'sd512;
			22: r = 32'sd256;
			default: r = 32'sd128;
		endcase
		return r;
	endfunction

endpackage

>>> src/pctra_if.sv
// Stream channel interfaces for image points and camera-frame results.
// Depends on nothing.
`timescale 1ns / 1ps

interface pctra_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_x;
	logic [15:0] pixel_y;
	logic [15:0] distance;

	modport source(output valid, pixel_x, pixel_y, distance, input ready);
	modport sink(input valid, pixel_x, pixel_y, distance, output ready);
endinterface

interface pctra_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] cam_x;
	logic signed [31:0] cam_y;
	logic [15:0]        cam_z;
	logic signed [15:0] pitch_angle;
	logic signed [15:0] yaw_angle;
	logic               saturated;

	modport source(output valid, cam_x, cam_y, cam_z, pitch_angle, yaw_angle, saturated,
		input ready);
	modport sink(input valid, cam_x, cam_y, cam_z, pitch_angle, yaw_angle, saturated,
		output ready);
endinterface

>>> src/pctra_cfg.sv
// APB-style register file holding principal point and focal lengths.
// Depends on pctra_pkg.
`timescale 1ns / 1ps

module pctra_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output pctra_pkg::cfg_t      cfg
);

	logic [1:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel & penable & pwrite;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.principal_x <= pctra_pkg::RST_PRINCIPAL_X;
			cfg.principal_y <= pctra_pkg::RST_PRINCIPAL_Y;
			cfg.focal_x     <= pctra_pkg::RST_FOCAL;
			cfg.focal_y     <= pctra_pkg::RST_FOCAL;
		end else if (wr) begin
			unique case (idx)
				pctra_pkg::REG_PRINCIPAL_X: cfg.principal_x <= pwdata[15:0];
				pctra_pkg::REG_PRINCIPAL_Y: cfg.principal_y <= pwdata[15:0];
				pctra_pkg::REG_FOCAL_X:     cfg.focal_x     <= pwdata[19:0];
				pctra_pkg::REG_FOCAL_Y:     cfg.focal_y     <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		unique case (idx)
			pctra_pkg::REG_PRINCIPAL_X: prdata = {16'd0, cfg.principal_x};
			pctra_pkg::REG_PRINCIPAL_Y: prdata = {16'd0, cfg.principal_y};
			pctra_pkg::REG_FOCAL_X:     prdata = {12'd0, cfg.focal_x};
			pctra_pkg::REG_FOCAL_Y:     prdata = {12'd0, cfg.focal_y};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

>>> src/pctra_div.sv
// Pipelined restoring divider: one quotient bit per stage, DIV_BITS stages.
// Depends on pctra_pkg.
`timescale 1ns / 1ps

module pctra_div (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] dvd,
	input  logic [19:0] den,
	input  logic        neg,
	output logic [31:0] quo,
	output logic        quo_neg
);

	localparam int N = pctra_pkg::DIV_BITS;

	logic [19:0]  rem_s [N];
	logic [N-1:0] dvd_s [N];
	logic [N-1:0] quo_s [N];
	logic [19:0]  den_s [N];
	logic         neg_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [19:0]  rem_in;
		logic [N-1:0] dvd_in;
		logic [N-1:0] quo_in;
		logic [19:0]  den_in;
		logic         neg_in;
		logic [20:0]  trial;
		logic [20:0]  diff;
		logic         ge;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign dvd_in = {dvd, {(N - 32){1'b0}}};
			assign quo_in = '0;
			assign den_in = den;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign dvd_in = dvd_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
			assign neg_in = neg_s[k-1];
		end

		// Shift in the next dividend bit and subtract when it fits.
		assign trial = {rem_in, dvd_in[N-1]};
		assign diff  = trial - {1'b0, den_in};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[19:0] : trial[19:0];
				dvd_s[k] <= {dvd_in[N-2:0], 1'b0};
				quo_s[k] <= {quo_in[N-2:0], ge};
				den_s[k] <= den_in;
				neg_s[k] <= neg_in;
			end
		end
	end

	// The divisor is at least 16, so the quotient fits in 32 bits.
	assign quo     = quo_s[N-1][31:0];
	assign quo_neg = neg_s[N-1];

endmodule

>>> src/pctra_cordic.sv
// Pipelined vectoring CORDIC: one micro-rotation per stage, Q2.30 angle sum.
// Depends on pctra_pkg.
`timescale 1ns / 1ps

module pctra_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic signed [47:0] x0,
	input  logic signed [47:0] y0,
	output logic signed [31:0] z
);

	localparam int N = pctra_pkg::STEPS;

	logic signed [47:0] x_s [N];
	logic signed [47:0] y_s [N];
	logic signed [31:0] z_s [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [47:0] x_in;
		logic signed [47:0] y_in;
		logic signed [31:0] z_in;
		logic signed [47:0] xs;
		logic signed [47:0] ys;

		if (i == 0) begin : g_first
			assign x_in = x0;
			assign y_in = y0;
			assign z_in = '0;
		end else begin : g_next
			assign x_in = x_s[i-1];
			assign y_in = y_s[i-1];
			assign z_in = z_s[i-1];
		end

		assign xs = x_in >>> i;
		assign ys = y_in >>> i;

		// Rotate toward the axis; a zero residual leaves the vector alone.
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_in > 0) begin
					x_s[i] <= x_in + ys;
					y_s[i] <= y_in - xs;
					z_s[i] <= z_in + pctra_pkg::atan_q30(i);
				end else if (y_in < 0) begin
					x_s[i] <= x_in - ys;
					y_s[i] <= y_in + xs;
					z_s[i] <= z_in - pctra_pkg::atan_q30(i);
				end else begin
					x_s[i] <= x_in;
					y_s[i] <= y_in;
					z_s[i] <= z_in;
				end
			end
		end
	end

	assign z = z_s[N-1];

endmodule

>>> src/pctra_lane.sv
// One axis: offset, product, division by the focal length and view angle,
// with saturation and rounding in the output register.
// Depends on pctra_pkg, pctra_div and pctra_cordic.
`timescale 1ns / 1ps

module pctra_lane (
	input  logic                  clk,
	input  logic                  en,
	input  logic [15:0]           pix,
	input  logic [15:0]           prin,
	input  logic [19:0]           focal,
	input  logic [15:0]           obj_dist,
	output pctra_pkg::lane_res_t  res
);

	localparam int DLY = pctra_pkg::ANG_DLY;

	logic signed [16:0] off_s1;
	logic [19:0]        f_s1;
	logic [15:0]        d_s1;

	logic [31:0]        prod_s2;
	logic [19:0]        f_s2;
	logic               neg_s2;
	logic signed [47:0] cx_s2;
	logic signed [47:0] cy_s2;

	logic [15:0]        mag;
	logic [16:0]        off_abs;
	logic [31:0]        quo;
	logic               quo_neg;
	logic signed [31:0] z;
	logic signed [31:0] zd_s [DLY];
	logic signed [32:0] zsum;
	logic signed [16:0] zr;
	logic [31:0]        quo_twos;

	// Stage 1: signed offset and focal length clamped to one pixel.
	always_ff @(posedge clk) begin
		if (en) begin
			off_s1 <= $signed({1'b0, pix}) - $signed({1'b0, prin});
			f_s1   <= (focal < pctra_pkg::FOCAL_MIN) ? pctra_pkg::FOCAL_MIN : focal;
			d_s1   <= obj_dist;
		end
	end

	assign off_abs = off_s1[16] ? (17'd0 - off_s1) : off_s1;
	assign mag     = off_abs[15:0];

	// Stage 2: magnitude times distance, and the rotation start vector.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= mag * d_s1;
			f_s2    <= f_s1;
			neg_s2  <= off_s1[16];
			cx_s2   <= {4'd0, f_s1, 24'd0};
			cy_s2   <= {{7{off_s1[16]}}, off_s1, 24'd0};
		end
	end

	pctra_div u_div (
		.clk     (clk),
		.en      (en),
		.dvd     (prod_s2),
		.den     (f_s2),
		.neg     (neg_s2),
		.quo     (quo),
		.quo_neg (quo_neg)
	);

	pctra_cordic u_cordic (
		.clk (clk),
		.en  (en),
		.x0  (cx_s2),
		.y0  (cy_s2),
		.z   (z)
	);

	// Hold the angle until the quotient is ready.
	always_ff @(posedge clk) begin
		if (en) begin
			zd_s[0] <= z;
			for (int k = 1; k < DLY; k++) begin
				zd_s[k] <= zd_s[k-1];
			end
		end
	end

	// Round Q2.30 to Q2.14 by adding half and shifting down.
	assign zsum     = {zd_s[DLY-1][31], zd_s[DLY-1]} + 33'sd32768;
	assign zr       = zsum[32:16];
	assign quo_twos = 32'd0 - quo;

	// Output register: clip the coordinate and the angle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (!quo_neg) begin
				res.sat   <= quo[31];
				res.coord <= quo[31] ? 32'sh7FFF_FFFF : $signed(quo);
			end else begin
				res.sat   <= quo[31] && (quo[30:0] != 31'd0);
				res.coord <= quo[31] ? 32'sh8000_0000 : $signed(quo_twos);
			end
			if (zr > pctra_pkg::ANGLE_HI) begin
				res.angle <= pctra_pkg::ANGLE_HI[15:0];
			end else if (zr < pctra_pkg::ANGLE_LO) begin
				res.angle <= pctra_pkg::ANGLE_LO[15:0];
			end else begin
				res.angle <= zr[15:0];
			end
		end
	end

endmodule

>>> src/pixel_to_camera_ray_and_angles_top.sv
// Top level of the pinhole back-projection block: register file, two axis lanes,
// valid tracking and the result channel. Depends on pctra_pkg, pctra_if,
// pctra_cfg and pctra_lane.
//
//   channel   direction  beat contents
//   in_ch     sink       pixel_x, pixel_y, distance
//   out_ch    source     cam_x, cam_y, cam_z, pitch_angle, yaw_angle, saturated
//   apb       slave      principal_x, principal_y, focal_x, focal_y at 0x0..0xC
//
// One beat is accepted per clock unless a result waits untaken; each result passes
// through the input and product registers, the 36-stage restoring divider and the
// output register. The whole pipeline advances together; it holds while a result
// waits untaken, so a stall loses and repeats nothing. Reset clears the valid bits
// and loads the register defaults; there is no clearing pass.
`timescale 1ns / 1ps

module pixel_to_camera_ray_and_angles_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	pctra_in_if.sink     in_ch,
	pctra_out_if.source  out_ch
);

	localparam int LAT = pctra_pkg::LATENCY;

	pctra_pkg::cfg_t      cfg;
	pctra_pkg::lane_res_t res_x;
	pctra_pkg::lane_res_t res_y;
	logic                 en;
	logic [LAT-1:0]       vld_q;
	logic [15:0]          dist_s [LAT];

	pctra_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The pipeline moves when the output slot is empty or being taken.
	assign en          = !vld_q[LAT-1] || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	// Distance travels alongside as cam_z.
	always_ff @(posedge clk) begin
		if (en) begin
			dist_s[0] <= in_ch.distance;
			for (int k = 1; k < LAT; k++) begin
				dist_s[k] <= dist_s[k-1];
			end
		end
	end

	pctra_lane u_lane_x (
		.clk      (clk),
		.en       (en),
		.pix      (in_ch.pixel_x),
		.prin     (cfg.principal_x),
		.focal    (cfg.focal_x),
		.obj_dist (in_ch.distance),
		.res      (res_x)
	);

	pctra_lane u_lane_y (
		.clk      (clk),
		.en       (en),
		.pix      (in_ch.pixel_y),
		.prin     (cfg.principal_y),
		.focal    (cfg.focal_y),
		.obj_dist (in_ch.distance),
		.res      (res_y)
	);

	assign out_ch.valid       = vld_q[LAT-1];
	assign out_ch.cam_x       = res_x.coord;
	assign out_ch.cam_y       = res_y.coord;
	assign out_ch.cam_z       = dist_s[LAT-1];
	assign out_ch.pitch_angle = res_y.angle;
	assign out_ch.yaw_angle   = res_x.angle;
	assign out_ch.saturated   = res_x.sat | res_y.sat;

endmodule

>>> src/pctra_checker.sv
// Port-level checks for the back-projection block, bound to its top level.
// Depends on pixel_to_camera_ray_and_angles_top.
`timescale 1ns / 1ps

module pctra_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] cam_x,
	input logic signed [31:0] cam_y,
	input logic signed [15:0] pitch_angle,
	input logic signed [15:0] yaw_angle,
	input logic               saturated
);

	// A stalled result stays valid and holds its coordinates.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cam_x) && $stable(cam_y))
		else $error("result changed while stalled");

	// An empty output slot never blocks the input.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// The saturation flag only comes with a clipped coordinate.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> cam_x == 32'sh7FFF_FFFF || cam_x == 32'sh8000_0000
			|| cam_y == 32'sh7FFF_FFFF || cam_y == 32'sh8000_0000)
		else $error("saturated without a clipped coordinate");

	// Angles stay within plus or minus pi/2.
	a_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pitch_angle <= 16'sd25736 && pitch_angle >= -16'sd25736
			&& yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736)
		else $error("angle out of range");

endmodule

bind pixel_to_camera_ray_and_angles_top pctra_checker u_pctra_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.cam_x       (out_ch.cam_x),
	.cam_y       (out_ch.cam_y),
	.pitch_angle (out_ch.pitch_angle),
	.yaw_angle   (out_ch.yaw_angle),
	.saturated   (out_ch.saturated)
);

>>> bench/pctra_ray_checker.sv
// Checker for the pixel-to-camera ray block: follows the register port and both
// stream channels, predicts each camera-frame result and compares it field by field.
// Depends on pctra_pkg and the pctra_in_if / pctra_out_if interfaces.
`timescale 1ns / 1ps

module pctra_ray_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	pctra_in_if         in_ch,
	pctra_out_if        out_ch,
	output int          mismatches,
	output int          rays_waiting,
	output int          rays_checked,
	output int          rays_clipped
);

	typedef struct packed {
		logic signed [31:0] cam_x;
		logic signed [31:0] cam_y;
		logic [15:0]        cam_z;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic               sat;
	} ray_t;

	ray_t        expected_rays[$];
	pctra_pkg::cfg_t cam_cfg;
	longint      arctan_q30[24];

	// Arctangent of 2^-i in Q2.30 for the vectoring iterations.
	initial begin
		arctan_q30 = '{843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
			16775852, 8388438, 4194283, 2097149, 1048576, 524288, 262144, 131072,
			65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
	end

	// Vectoring rotation of (den, offs) toward the x axis, angle rounded to Q2.14.
	function automatic logic [15:0] view_angle_q14(longint offs, longint den);
		longint vx, vy, acc, sx, sy;
		vx = den <<< 24;
		vy = offs <<< 24;
		acc = 0;
		for (int i = 0; i < pctra_pkg::STEPS; i++) begin
			sx = vx >>> i;
			sy = vy >>> i;
			if (vy > 0) begin
				vx = vx + sy;
				vy = vy - sx;
				acc = acc + arctan_q30[i];
			end else if (vy < 0) begin
				vx = vx - sy;
				vy = vy + sx;
				acc = acc - arctan_q30[i];
			end
		end
		acc = (acc + 32768) >>> 16;
		if (acc > 25736)
			acc = 25736;
		if (acc < -25736)
			acc = -25736;
		return acc[15:0];
	endfunction

	// Offset times distance over focal length, 4 fraction bits, toward zero, clipped.
	function automatic logic [31:0] scaled_coord(longint offs, longint d, longint f,
		output bit clipped);
		longint mag, q;
		clipped = 1'b0;
		mag = (offs < 0) ? -offs : offs;
		q = (mag * d * 16) / f;
		if (offs >= 0) begin
			if (q > 64'sd2147483647) begin
				q = 64'sd2147483647;
				clipped = 1'b1;
			end
			return q[31:0];
		end
		if (q > 64'sd2147483648) begin
			q = 64'sd2147483648;
			clipped = 1'b1;
		end
		q = -q;
		return q[31:0];
	endfunction

	function automatic ray_t predict_ray(logic [15:0] u, logic [15:0] v, logic [15:0] d);
		ray_t   r;
		longint fx, fy, du, dv;
		bit     cx, cy;
		fx = (cam_cfg.focal_x < pctra_pkg::FOCAL_MIN) ? 16 : cam_cfg.focal_x;
		fy = (cam_cfg.focal_y < pctra_pkg::FOCAL_MIN) ? 16 : cam_cfg.focal_y;
		du = longint'(u) - longint'(cam_cfg.principal_x);
		dv = longint'(v) - longint'(cam_cfg.principal_y);
		r.cam_x = scaled_coord(du, d, fx, cx);
		r.cam_y = scaled_coord(dv, d, fy, cy);
		r.cam_z = d;
		r.pitch = view_angle_q14(dv, fy);
		r.yaw = view_angle_q14(du, fx);
		r.sat = cx | cy;
		return r;
	endfunction

	// Register writes, accepted points and delivered rays, all sampled at the edge.
	always @(posedge clk or negedge arst_n) begin
		ray_t want;
		if (!arst_n) begin
			expected_rays.delete();
			cam_cfg.principal_x <= pctra_pkg::RST_PRINCIPAL_X;
			cam_cfg.principal_y <= pctra_pkg::RST_PRINCIPAL_Y;
			cam_cfg.focal_x <= pctra_pkg::RST_FOCAL;
			cam_cfg.focal_y <= pctra_pkg::RST_FOCAL;
			mismatches <= 0;
			rays_checked <= 0;
			rays_clipped <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					pctra_pkg::REG_PRINCIPAL_X: cam_cfg.principal_x <= pwdata[15:0];
					pctra_pkg::REG_PRINCIPAL_Y: cam_cfg.principal_y <= pwdata[15:0];
					pctra_pkg::REG_FOCAL_X:     cam_cfg.focal_x <= pwdata[19:0];
					default:                    cam_cfg.focal_y <= pwdata[19:0];
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				expected_rays.push_back(predict_ray(in_ch.pixel_x, in_ch.pixel_y,
					in_ch.distance));
			if (out_ch.valid && out_ch.ready) begin
				if (expected_rays.size() == 0) begin
					$error("ray beat with no point outstanding");
					mismatches <= mismatches + 1;
				end else begin
					want = expected_rays.pop_front();
					rays_checked <= rays_checked + 1;
					if (want.sat)
						rays_clipped <= rays_clipped + 1;
					if ({out_ch.cam_x, out_ch.cam_y, out_ch.cam_z, out_ch.pitch_angle,
						out_ch.yaw_angle, out_ch.saturated} !== want) begin
						mismatches <= mismatches + 1;
						if (out_ch.cam_x !== want.cam_x)
							$error("cam_x expected %0d actual %0d", want.cam_x, out_ch.cam_x);
						if (out_ch.cam_y !== want.cam_y)
							$error("cam_y expected %0d actual %0d", want.cam_y, out_ch.cam_y);
						if (out_ch.cam_z !== want.cam_z)
							$error("cam_z expected %0d actual %0d", want.cam_z, out_ch.cam_z);
						if (out_ch.pitch_angle !== want.pitch)
							$error("pitch_angle expected %0d actual %0d", want.pitch,
								out_ch.pitch_angle);
						if (out_ch.yaw_angle !== want.yaw)
							$error("yaw_angle expected %0d actual %0d", want.yaw,
								out_ch.yaw_angle);
						if (out_ch.saturated !== want.sat)
							$error("saturated expected %0b actual %0b", want.sat,
								out_ch.saturated);
					end
				end
			end
		end
		rays_waiting = expected_rays.size();
	end

endmodule

>>> bench/pixel_to_camera_ray_and_angles_top_tb.sv
// Testbench top for the pixel-to-camera ray block: clock, reset, register setup,
// point stimulus and result back-pressure; the verdict comes from pctra_ray_checker.
// Depends on pctra_pkg, the channel interfaces and the block itself.
`timescale 1ns / 1ps

module pixel_to_camera_ray_and_angles_top_tb;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int          mismatches, rays_waiting, rays_checked, rays_clipped;
	int          points_sent;
	bit          steady;
	logic [15:0] cur_u0, cur_v0;

	pctra_in_if  in_ch();
	pctra_out_if out_ch();

	pixel_to_camera_ray_and_angles_top dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	pctra_ray_checker checker_i (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.pready(pready), .paddr(paddr), .pwdata(pwdata), .in_ch(in_ch), .out_ch(out_ch),
		.mismatches(mismatches), .rays_waiting(rays_waiting),
		.rays_checked(rays_checked), .rays_clipped(rays_clipped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the pipeline hangs.
	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

	// Result back-pressure, switched off during the steady stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= steady || ($urandom_range(0, 99) >= 22);
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_camera(logic [15:0] u0, logic [15:0] v0, logic [19:0] fx,
		logic [19:0] fy);
		write_reg(pctra_pkg::REG_PRINCIPAL_X, ({$urandom} & 32'hFFFF_0000) | {16'h0, u0});
		write_reg(pctra_pkg::REG_PRINCIPAL_Y, {16'h0, v0});
		write_reg(pctra_pkg::REG_FOCAL_X, ({$urandom} & 32'hFFF0_0000) | {12'h0, fx});
		write_reg(pctra_pkg::REG_FOCAL_Y, {12'h0, fy});
		cur_u0 = u0;
		cur_v0 = v0;
	endtask

	// One point beat: random gap, then hold valid until the block takes it.
	task automatic send_point(logic [15:0] u, logic [15:0] v, logic [15:0] d);
		bit taken;
		while (!steady && $urandom_range(0, 99) < 22) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pixel_x <= u;
		in_ch.pixel_y <= v;
		in_ch.distance <= d;
		do begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end while (!taken);
		points_sent++;
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (rays_waiting != 0)
			@(posedge clk);
		repeat (pctra_pkg::LATENCY + 4) @(posedge clk);
	endtask

	// Random point; sometimes on the principal point, distance sometimes small.
	task automatic random_point;
		logic [15:0] u, v, d;
		u = 16'($urandom);
		v = 16'($urandom);
		if ($urandom_range(0, 9) == 0)
			u = cur_u0;
		if ($urandom_range(0, 9) == 0)
			v = cur_v0;
		d = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom);
		send_point(u, v, d);
	endtask

	function automatic logic [19:0] random_focal();
		case ($urandom_range(0, 3))
			0:       return 20'($urandom_range(0, 2047));
			1:       return 20'($urandom_range(16, 1048575));
			default: return 20'($urandom_range(256, 65535));
		endcase
	endfunction

	initial begin
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.pixel_x = '0;
		in_ch.pixel_y = '0;
		in_ch.distance = '0;
		points_sent = 0;
		steady = 1'b0;
		cur_u0 = pctra_pkg::RST_PRINCIPAL_X;
		cur_v0 = pctra_pkg::RST_PRINCIPAL_Y;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: field extremes and the principal point itself.
		send_point(16'd0, 16'd0, 16'd0);
		send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_point(16'd0, 16'hFFFF, 16'hFFFF);
		send_point(16'hFFFF, 16'd0, 16'd1);
		send_point(cur_u0, cur_v0, 16'hFFFF);
		send_point(cur_u0 + 16'd1, cur_v0 - 16'd1, 16'd1000);
		drain();

		// Smallest focal lengths and far corners, where both coordinates can clip.
		set_camera(16'd0, 16'hFFFF, 20'd16, 20'd16);
		send_point(16'hFFFF, 16'd0, 16'hFFFF);
		send_point(16'd0, 16'hFFFF, 16'hFFFF);
		send_point(16'd1, 16'hFFFE, 16'd1);
		send_point(16'hFFFF, 16'd0, 16'd0);
		drain();

		// Focal values under one pixel are raised to one pixel.
		set_camera(16'h8000, 16'h7FFF, 20'd0, 20'd15);
		send_point(16'hFFFF, 16'd0, 16'hFFFF);
		send_point(16'h8000, 16'h7FFF, 16'h1234);
		send_point(16'h0, 16'hFFFF, 16'd77);
		drain();

		// Largest focal lengths and principal point at the opposite corners.
		set_camera(16'hFFFF, 16'd0, 20'hFFFFF, 20'hFFFFF);
		send_point(16'd0, 16'hFFFF, 16'hFFFF);
		send_point(16'hFFFF, 16'd0, 16'hFFFF);
		send_point(16'h5555, 16'hAAAA, 16'h5A5A);
		drain();

		// Random phases, each under a new camera; one phase runs without any idling.
		for (int phase = 0; phase < 8; phase++) begin
			set_camera(16'($urandom), 16'($urandom), random_focal(), random_focal());
			steady = (phase == 3);
			repeat (175) random_point();
			steady = 1'b0;
			drain();
		end

		$display("Sent %0d points over 12 camera settings; %0d rays checked, %0d clipped.",
			points_sent, rays_checked, rays_clipped);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> filelist.f
src/pctra_pkg.sv
src/pctra_if.sv
src/pctra_cfg.sv
src/pctra_div.sv
src/pctra_cordic.sv
src/pctra_lane.sv
src/pixel_to_camera_ray_and_angles_top.sv
src/pctra_checker.sv
bench/pctra_ray_checker.sv
bench/pixel_to_camera_ray_and_angles_top_tb.sv
